// ===== hdl/ffba_pkg.sv =====
// Package for the first-fit block allocator: field widths, command and
// status codes, cell operations and controller states.
// No dependencies.
package ffba_pkg;

  // Port field widths
  localparam int CMD_W    = 2;
  localparam int REQ_W    = 14;
  localparam int OFFS_W   = 13;
  localparam int STAT_W   = 2;

  // Default geometry
  localparam int HEAP_BYTES_DEF   = 8192;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int MAX_BLOCKS_DEF   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_BADFREE = 2'd2
  } status_t;

  // Operation broadcast to every cell of the block table
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_ROT,
    OP_WR,
    OP_INS,
    OP_DEL
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_EVAL,
    S_INS,
    S_DEL,
    S_DONE
  } state_t;

endpackage

// ===== hdl/ffba_cell.sv =====
// One entry of the block table: payload size and used flag.
// Loads from its left or right neighbor, or from the write bus; uses ffba_pkg.
module ffba_cell #(
  parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int CELL_IDX     = 0,
  localparam int PW = $clog2(HEAP_BYTES + 1),
  localparam int IW = $clog2(MAX_BLOCKS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffba_pkg::cell_op_t   op,
  input  logic [IW-1:0]        idx,
  input  logic                 wr_used,
  input  logic [PW-1:0]        wr_pay,
  input  logic                 left_used,
  input  logic [PW-1:0]        left_pay,
  input  logic                 right_used,
  input  logic [PW-1:0]        right_pay,
  output logic                 used,
  output logic [PW-1:0]        pay
);
  import ffba_pkg::*;

  localparam logic [IW-1:0] MY_IDX   = IW'(CELL_IDX);
  localparam logic [PW-1:0] INIT_PAY = (CELL_IDX == 0) ? PW'(HEAP_BYTES - HEADER_BYTES) : '0;

  logic          used_r, used_nxt;
  logic [PW-1:0] pay_r, pay_nxt;

  // next entry value per broadcast operation
  always_comb begin
    used_nxt = used_r;
    pay_nxt  = pay_r;
    unique case (op)
      OP_HOLD: begin
      end
      OP_INIT: begin
        used_nxt = 1'b0;
        pay_nxt  = INIT_PAY;
      end
      OP_ROT: begin
        used_nxt = right_used;
        pay_nxt  = right_pay;
      end
      OP_WR: begin
        if (idx == MY_IDX) begin
          used_nxt = wr_used;
          pay_nxt  = wr_pay;
        end
      end
      OP_INS: begin
        if (idx == MY_IDX) begin
          used_nxt = wr_used;
          pay_nxt  = wr_pay;
        end else if (MY_IDX > idx) begin
          used_nxt = left_used;
          pay_nxt  = left_pay;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= idx) begin
          used_nxt = right_used;
          pay_nxt  = right_pay;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      pay_r  <= INIT_PAY;
    end else begin
      used_r <= used_nxt;
      pay_r  <= pay_nxt;
    end
  end

  assign used = used_r;
  assign pay  = pay_r;

endmodule

// ===== hdl/ffba_ctrl.sv =====
// Sequencer of the allocator: scans the rotating block table from its head
// cell, then drives write, insert and delete operations; holds the result word.
// Uses ffba_pkg.
module ffba_ctrl #(
  parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  localparam int PW = $clog2(HEAP_BYTES + 1),
  localparam int IW = $clog2(MAX_BLOCKS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ffba_pkg::CMD_W-1:0]   in_command,
  input  logic [ffba_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [ffba_pkg::OFFS_W-1:0]  in_release_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ffba_pkg::STAT_W-1:0]  out_status,
  output logic [ffba_pkg::OFFS_W-1:0]  out_block_offset,
  output logic [ffba_pkg::REQ_W-1:0]   out_granted_bytes,
  input  logic                         head_used,
  input  logic [PW-1:0]                head_pay,
  output ffba_pkg::cell_op_t           cell_op,
  output logic [IW-1:0]                cell_idx,
  output logic                         cell_wr_used,
  output logic [PW-1:0]                cell_wr_pay
);
  import ffba_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CW    = (PW > REQ_W) ? PW : REQ_W;
  localparam int OW    = (PW > OFFS_W) ? PW : OFFS_W;
  localparam int SW    = PW + 2;

  state_t             state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r;
  logic [REQ_W-1:0]   req_r;
  logic [OFFS_W-1:0]  rel_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IW-1:0]      step_r;
  logic [PW-1:0]      off_r;
  logic               found_r, grab_r;
  logic [IW-1:0]      fidx_r, del_idx_r;
  logic               fused_r, fprev_used_r, prev_used_r;
  logic [PW-1:0]      fpay_r, foff_r, fprev_pay_r, prev_pay_r;
  logic               nxt_valid_r, nxt_used_r;
  logic [PW-1:0]      nxt_pay_r, ins_pay_r;
  logic [1:0]         del_left_r;
  logic [STAT_W-1:0]  res_status_r, out_status_r;
  logic [OFFS_W-1:0]  res_off_r, out_off_r;
  logic [REQ_W-1:0]   res_bytes_r, out_bytes_r;
  logic               out_valid_r;

  logic               is_alloc, is_free, head_valid, alloc_hit, free_hit;
  logic [CW-1:0]      rem;
  logic               split, free_ok, nmerge, pmerge;
  logic [SW-1:0]      cur_sum, prev_sum;
  logic [1:0]         dels;
  logic               out_free;

  // scan and evaluation terms
  always_comb begin
    is_alloc   = (cmd_r == CMD_ALLOC);
    is_free    = (cmd_r == CMD_FREE);
    head_valid = (CNT_W'(step_r) < cnt_r);
    alloc_hit  = is_alloc && !head_used && (CW'(head_pay) >= CW'(req_r));
    free_hit   = is_free && (OW'(off_r) == OW'(rel_r));
    rem        = CW'(fpay_r) - CW'(req_r);
    split      = found_r && (rem > CW'(HEADER_BYTES)) && (cnt_r < CNT_W'(MAX_BLOCKS));
    free_ok    = found_r && fused_r;
    nmerge     = nxt_valid_r && !nxt_used_r;
    pmerge     = (fidx_r != '0) && !fprev_used_r;
    cur_sum    = SW'(fpay_r) + (nmerge ? (SW'(nxt_pay_r) + SW'(HEADER_BYTES)) : '0);
    prev_sum   = SW'(fprev_pay_r) + cur_sum + SW'(HEADER_BYTES);
    dels       = {1'b0, nmerge} + {1'b0, pmerge};
    out_free   = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_command == CMD_INIT) state_nxt = S_INIT;
          else if (in_command == CMD_ALLOC || in_command == CMD_FREE) state_nxt = S_SCAN;
          else state_nxt = S_DONE;
        end
      end
      S_INIT: state_nxt = S_DONE;
      S_SCAN: begin
        if (step_r == IW'(MAX_BLOCKS - 1)) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (is_alloc && split) state_nxt = S_INS;
        else if (is_free && free_ok && dels != 2'd0) state_nxt = S_DEL;
        else state_nxt = S_DONE;
      end
      S_INS: state_nxt = S_DONE;
      S_DEL: begin
        if (del_left_r == 2'd1) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // operation broadcast to the cells
  always_comb begin
    cell_op      = OP_HOLD;
    cell_idx     = '0;
    cell_wr_used = 1'b0;
    cell_wr_pay  = '0;
    unique case (state_r)
      S_INIT: cell_op = OP_INIT;
      S_SCAN: cell_op = OP_ROT;
      S_EVAL: begin
        if (is_alloc && found_r) begin
          cell_op      = OP_WR;
          cell_idx     = fidx_r;
          cell_wr_used = 1'b1;
          cell_wr_pay  = split ? PW'(req_r) : fpay_r;
        end else if (is_free && free_ok) begin
          cell_op = OP_WR;
          if (pmerge) begin
            cell_idx    = fidx_r - IW'(1);
            cell_wr_pay = PW'(prev_sum);
          end else begin
            cell_idx    = fidx_r;
            cell_wr_pay = PW'(cur_sum);
          end
        end
      end
      S_INS: begin
        cell_op     = OP_INS;
        cell_idx    = fidx_r + IW'(1);
        cell_wr_pay = ins_pay_r;
      end
      S_DEL: begin
        cell_op  = OP_DEL;
        cell_idx = del_idx_r;
      end
      default: begin
      end
    endcase
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CNT_W'(1);
      step_r      <= '0;
      found_r     <= 1'b0;
      grab_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r        <= in_command;
            req_r        <= in_request_bytes;
            rel_r        <= in_release_offset;
            off_r        <= '0;
            found_r      <= 1'b0;
            grab_r       <= 1'b0;
            nxt_valid_r  <= 1'b0;
            res_status_r <= STAT_OK;
            res_off_r    <= '0;
            res_bytes_r  <= '0;
          end
        end
        S_INIT: begin
          cnt_r       <= CNT_W'(1);
          res_bytes_r <= REQ_W'(HEAP_BYTES - HEADER_BYTES);
        end
        S_SCAN: begin
          step_r      <= (step_r == IW'(MAX_BLOCKS - 1)) ? '0 : step_r + IW'(1);
          prev_used_r <= head_used;
          prev_pay_r  <= head_pay;
          if (head_valid && !found_r) begin
            if (alloc_hit || free_hit) begin
              found_r      <= 1'b1;
              grab_r       <= 1'b1;
              fidx_r       <= step_r;
              fused_r      <= head_used;
              fpay_r       <= head_pay;
              foff_r       <= off_r;
              fprev_used_r <= prev_used_r;
              fprev_pay_r  <= prev_pay_r;
            end else begin
              off_r <= off_r + head_pay + PW'(HEADER_BYTES);
            end
          end
          // pick up the neighbor that follows the match
          if (grab_r) begin
            grab_r      <= 1'b0;
            nxt_valid_r <= head_valid;
            nxt_used_r  <= head_used;
            nxt_pay_r   <= head_pay;
          end
        end
        S_EVAL: begin
          if (is_alloc) begin
            if (!found_r) begin
              res_status_r <= STAT_NOSPACE;
            end else begin
              res_off_r   <= OFFS_W'(foff_r);
              res_bytes_r <= split ? req_r : REQ_W'(fpay_r);
              ins_pay_r   <= PW'(rem - CW'(HEADER_BYTES));
            end
          end else if (is_free) begin
            if (!free_ok) begin
              res_status_r <= STAT_BADFREE;
              res_off_r    <= rel_r;
            end else begin
              res_off_r   <= OFFS_W'(foff_r);
              res_bytes_r <= REQ_W'(fpay_r);
              del_left_r  <= dels;
              del_idx_r   <= pmerge ? fidx_r : fidx_r + IW'(1);
            end
          end
        end
        S_INS: cnt_r <= cnt_r + CNT_W'(1);
        S_DEL: begin
          cnt_r      <= cnt_r - CNT_W'(1);
          del_left_r <= del_left_r - 2'd1;
        end
        S_DONE: begin
          // load the result word, or keep the old one while it is still waiting
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_off_r    <= res_off_r;
            out_bytes_r  <= res_bytes_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_offset  = out_off_r;
  assign out_granted_bytes = out_bytes_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word loaded outside the done state");
  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> (step_r == '0))
    else $error("scan counter not parked at zero");
  a_del_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL) |-> (del_left_r != 2'd0))
    else $error("delete step with nothing left to remove");
`endif

endmodule

// ===== hdl/first_fit_block_allocator_top.sv =====
// First-fit heap allocator with coalescing over a ring of table cells.
// Steps from accept to result: an unused code goes straight to the result, init resets
// the table; allocate/free take one full rotation of the cell chain past the head cell,
// one evaluate step, then one insert or up to two deletes.
// Throughput: one command in flight; the next word is taken the cycle after the result
// word is registered. Reset (sync, active low) leaves one free block covering the heap.
module first_fit_block_allocator_top #(
  parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ffba_pkg::CMD_W-1:0]   in_command,
  input  logic [ffba_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [ffba_pkg::OFFS_W-1:0]  in_release_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ffba_pkg::STAT_W-1:0]  out_status,
  output logic [ffba_pkg::OFFS_W-1:0]  out_block_offset,
  output logic [ffba_pkg::REQ_W-1:0]   out_granted_bytes
);
  import ffba_pkg::*;

  localparam int PW = $clog2(HEAP_BYTES + 1);
  localparam int IW = $clog2(MAX_BLOCKS);

  cell_op_t       cell_op;
  logic [IW-1:0]  cell_idx;
  logic           cell_wr_used;
  logic [PW-1:0]  cell_wr_pay;
  logic           cell_used [MAX_BLOCKS];
  logic [PW-1:0]  cell_pay  [MAX_BLOCKS];

  ffba_ctrl #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_request_bytes  (in_request_bytes),
    .in_release_offset (in_release_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_block_offset  (out_block_offset),
    .out_granted_bytes (out_granted_bytes),
    .head_used         (cell_used[0]),
    .head_pay          (cell_pay[0]),
    .cell_op           (cell_op),
    .cell_idx          (cell_idx),
    .cell_wr_used      (cell_wr_used),
    .cell_wr_pay       (cell_wr_pay)
  );

  // ring of table cells; the tail wraps to the head for rotation
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    localparam int LI = (k + MAX_BLOCKS - 1) % MAX_BLOCKS;
    localparam int RI = (k + 1) % MAX_BLOCKS;
    ffba_cell #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS),
      .CELL_IDX     (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (cell_op),
      .idx        (cell_idx),
      .wr_used    (cell_wr_used),
      .wr_pay     (cell_wr_pay),
      .left_used  (cell_used[LI]),
      .left_pay   (cell_pay[LI]),
      .right_used (cell_used[RI]),
      .right_pay  (cell_pay[RI]),
      .used       (cell_used[k]),
      .pay        (cell_pay[k])
    );
  end

endmodule
